// ===== hdl/obrb_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// obrb_pkg
// Shared types and constants of the overwrite byte ring buffer.
// ---------------------------------------------------------------------------
package obrb_pkg;

	localparam int BYTE_W = 8;
	localparam int CNT_W  = 7;
	localparam int MODE_W = 2;

	// Operation code carried with each input item
	typedef enum logic [MODE_W-1:0] {
		MODE_WRITE    = 2'd0,
		MODE_READ_ALL = 2'd1,
		MODE_CLEAR    = 2'd2
	} mode_t;

	// Control sequencer states
	typedef enum logic {
		ST_IDLE  = 1'b0,
		ST_DRAIN = 1'b1
	} state_t;

endpackage
`default_nettype wire

// ===== hdl/obrb_ram.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// obrb_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module obrb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read; data holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== hdl/overwrite_byte_ring_buffer_top.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// overwrite_byte_ring_buffer_top
// Byte ring buffer that keeps the newest bytes, with read-all and clear.
// ---------------------------------------------------------------------------
// Writes, clears and read-all on an empty ring run back to back as long
// as the result side keeps up. A read-all of stored bytes holds the input
// until its last byte enters the output register: one byte leaves per cycle
// while the result side keeps up, paced by the single read port of the byte
// RAM and its registered read. Writing to a full ring drops the oldest byte.
// Writing the capacity register empties the ring. The RAM needs no clearing after reset.
// ---------------------------------------------------------------------------
module overwrite_byte_ring_buffer_top #(
	parameter int DEPTH = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration: capacity
	input  wire logic        cfg_valid,
	output      logic        cfg_ready,
	input  wire logic [6:0]  cfg_data,
	// input items
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
	input  wire logic [1:0]  s_tuser,   // [1:0] mode
	input  wire logic        s_tlast,   // burst_end
	// result items
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	output      logic [15:0] m_tdata,   // [7:0] out_byte, [14:8] stored_count, [15] empty_res
	output      logic        m_tuser,   // status
	output      logic        m_tlast    // last
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = obrb_pkg::CNT_W;
	localparam logic [CW-1:0] CAP_MAX = CW'(DEPTH);

	obrb_pkg::state_t state_q, state_d;

	logic [CW-1:0] cap_q;
	logic [CW-1:0] cap_eff;
	logic [PW-1:0] wp_q, rp_q;
	logic [PW-1:0] wp_next, rp_next;
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_wr;
	logic          empty_q;
	logic [CW-1:0] remain_q;
	logic          rd_v_s1, rd_last_s1;
	logic [7:0]    rd_data;
	logic          out_free;
	logic          issue;
	logic          s_acc, cfg_acc;
	logic          wr_en;
	logic          full;
	obrb_pkg::mode_t mode;

	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid & cfg_ready;
	assign s_acc     = s_tvalid & s_tready;
	assign mode      = obrb_pkg::mode_t'(s_tuser);
	assign out_free  = !m_tvalid || m_tready;

	// Capacity clamped into 1..DEPTH
	always_comb begin
		if (cap_q == '0) begin
			cap_eff = CW'(1);
		end else if (cap_q > CAP_MAX) begin
			cap_eff = CAP_MAX;
		end else begin
			cap_eff = cap_q;
		end
	end

	// Pointer increments with wrap at capacity
	always_comb begin
		logic [CW-1:0] wi, ri;
		wi = CW'(wp_q) + CW'(1);
		ri = CW'(rp_q) + CW'(1);
		wp_next = (wi >= cap_eff) ? '0 : wi[PW-1:0];
		rp_next = (ri >= cap_eff) ? '0 : ri[PW-1:0];
	end

	assign full     = (count_q == cap_eff);
	assign count_wr = full ? cap_eff : count_q + CW'(1);
	assign wr_en    = s_acc && (mode == obrb_pkg::MODE_WRITE);

	// Sequencer: next state, input ready, RAM read issue
	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		issue    = 1'b0;
		unique case (state_q)
			obrb_pkg::ST_IDLE: begin
				s_tready = out_free;
				if (s_acc && mode == obrb_pkg::MODE_READ_ALL && count_q != '0) begin
					state_d = obrb_pkg::ST_DRAIN;
				end
			end
			obrb_pkg::ST_DRAIN: begin
				issue = (remain_q != '0) && (!rd_v_s1 || out_free);
				if (rd_v_s1 && out_free && rd_last_s1) begin
					state_d = obrb_pkg::ST_IDLE;
				end
			end
			default: state_d = obrb_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= obrb_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Ring control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q    <= CW'(64);
			wp_q     <= '0;
			rp_q     <= '0;
			count_q  <= '0;
			empty_q  <= 1'b1;
			remain_q <= '0;
		end else if (cfg_acc) begin
			cap_q   <= cfg_data;
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
			empty_q <= 1'b1;
		end else begin
			if (s_acc) begin
				case (mode)
					obrb_pkg::MODE_WRITE: begin
						wp_q    <= wp_next;
						count_q <= count_wr;
						empty_q <= 1'b0;
						if (full) begin
							rp_q <= rp_next;
						end
					end
					obrb_pkg::MODE_READ_ALL: begin
						remain_q <= count_q;
						count_q  <= '0;
						empty_q  <= 1'b1;
					end
					obrb_pkg::MODE_CLEAR: begin
						wp_q    <= '0;
						rp_q    <= '0;
						count_q <= '0;
						empty_q <= 1'b1;
					end
					default: ;
				endcase
			end
			if (issue) begin
				rp_q     <= rp_next;
				remain_q <= remain_q - CW'(1);
			end
		end
	end

	// Read pipeline valid; data held in the RAM output while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1    <= 1'b0;
			rd_last_s1 <= 1'b0;
		end else if (issue) begin
			rd_v_s1    <= 1'b1;
			rd_last_s1 <= (remain_q == CW'(1));
		end else if (out_free) begin
			rd_v_s1 <= 1'b0;
		end
	end

	obrb_ram #(
		.WIDTH(obrb_pkg::BYTE_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wp_q),
		.wdata(s_tdata),
		.re   (issue),
		.raddr(rp_q),
		.rdata(rd_data)
	);

	// Output register valid; a non-empty read-all answers through the drain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (rd_v_s1 && out_free) begin
			m_tvalid <= 1'b1;
		end else if (s_acc && ((mode == obrb_pkg::MODE_READ_ALL && count_q == '0) ||
				mode == obrb_pkg::MODE_CLEAR ||
				(mode == obrb_pkg::MODE_WRITE && s_tlast))) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (rd_v_s1 && out_free) begin
			m_tdata <= {1'b1, CW'(0), rd_data};
			m_tuser <= 1'b0;
			m_tlast <= rd_last_s1;
		end else if (s_acc) begin
			m_tlast <= 1'b1;
			case (mode)
				obrb_pkg::MODE_WRITE: begin
					m_tdata <= {1'b0, count_wr, 8'd0};
					m_tuser <= 1'b0;
				end
				obrb_pkg::MODE_READ_ALL: begin
					m_tdata <= {1'b1, CW'(0), 8'd0};
					m_tuser <= 1'b1;
				end
				default: begin
					m_tdata <= {1'b1, CW'(0), 8'd0};
					m_tuser <= 1'b0;
				end
			endcase
		end
	end

	// Checks
	a_count_le_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= cap_eff)
		else $error("stored count above capacity");

	a_no_accept_drain: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == obrb_pkg::ST_DRAIN |-> !s_tready)
		else $error("input accepted during drain");

	a_rd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rd_v_s1 && !out_free |=> rd_v_s1 && $stable(rd_data))
		else $error("read data lost under stall");

	a_write_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en && !cfg_acc |=> !empty_q && count_q != '0)
		else $error("ring empty after write");

	a_issue_remaining: assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> remain_q != '0 && state_q == obrb_pkg::ST_DRAIN)
		else $error("read issued with nothing left");

endmodule
`default_nettype wire
